// ===== src/pmc_pkg.sv =====
// Shared types, sizes and codes for the page map cache.
// Used by pmc_ctrl, pmc_dp and the top level; depends on nothing.
package pmc_pkg;

	localparam int NUM_IMAGES = 4;
	localparam int WAYS       = 32;
	localparam int SETS       = 32;   // power of two: set is the low page bits
	localparam int PAGE_SHIFT = 12;

	localparam int TAG_W   = 64 - PAGE_SHIFT;
	localparam int LOC_N   = SETS * WAYS;
	localparam int TOTAL_N = NUM_IMAGES * LOC_N;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LOC_W   = (LOC_N > 1) ? $clog2(LOC_N) : 1;
	localparam int ADDR_W  = (TOTAL_N > 1) ? $clog2(TOTAL_N) : 1;
	localparam int CNT_W   = 11;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_FILL   = 2'd1,
		OP_INVAL  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT    = 3'd0,
		ST_MISS   = 3'd1,
		ST_FILLED = 3'd2,
		ST_FAILED = 3'd3,
		ST_NOWAY  = 3'd4,
		ST_INVAL  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DRAIN,
		S_FINISH,
		S_SWEEP,
		S_SDRAIN
	} state_t;

	// One way of one set
	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic [63:0]      base;
		logic [63:0]      stamp;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic dispatch;
		logic clear_wr;
		logic scan_rd;
		logic sweep_rd;
		logic finish;
		logic quick;
		logic sweep_fin;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic quick;
		logic inval;
		logic clear_last;
		logic scan_last;
		logic sweep_last;
	} sts_t;

endpackage

// ===== src/pmc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/pmc_ctrl.sv =====
// Sequencer for the page map cache: clearing pass, set scans, image sweeps.
// Depends on pmc_pkg.
module pmc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pmc_pkg::sts_t   sts,
	output pmc_pkg::cmd_t   cmd,
	output logic            busy
);

	pmc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmc_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pmc_pkg::S_CLEAR: begin
				if (sts.clear_last) state_d = pmc_pkg::S_IDLE;
			end
			pmc_pkg::S_IDLE: begin
				if (start) state_d = pmc_pkg::S_DISPATCH;
			end
			pmc_pkg::S_DISPATCH: begin
				if (sts.quick) state_d = pmc_pkg::S_IDLE;
				else if (sts.inval) state_d = pmc_pkg::S_SWEEP;
				else state_d = pmc_pkg::S_SCAN;
			end
			pmc_pkg::S_SCAN: begin
				if (sts.scan_last) state_d = pmc_pkg::S_DRAIN;
			end
			pmc_pkg::S_DRAIN:  state_d = pmc_pkg::S_FINISH;
			pmc_pkg::S_FINISH: state_d = pmc_pkg::S_IDLE;
			pmc_pkg::S_SWEEP: begin
				if (sts.sweep_last) state_d = pmc_pkg::S_SDRAIN;
			end
			pmc_pkg::S_SDRAIN: state_d = pmc_pkg::S_IDLE;
			default:           state_d = pmc_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			pmc_pkg::S_CLEAR: cmd.clear_wr = 1'b1;
			pmc_pkg::S_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			pmc_pkg::S_DISPATCH: begin
				cmd.dispatch = 1'b1;
				cmd.quick = sts.quick;
			end
			pmc_pkg::S_SCAN:   cmd.scan_rd = 1'b1;
			pmc_pkg::S_DRAIN:  ;
			pmc_pkg::S_FINISH: cmd.finish = 1'b1;
			pmc_pkg::S_SWEEP:  cmd.sweep_rd = 1'b1;
			pmc_pkg::S_SDRAIN: cmd.sweep_fin = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== src/pmc_dp.sv =====
// Datapath of the page map cache: way store, use counters, scan compare, results.
// Depends on pmc_pkg and pmc_ram.
module pmc_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pmc_pkg::cmd_t             cmd,
	output pmc_pkg::sts_t             sts,
	input  logic [1:0]                operation,
	input  logic [1:0]                image,
	input  logic [63:0]               guest_address,
	input  logic [63:0]               mapped_base,
	input  logic                      map_ok,
	output logic                      done,
	output logic [2:0]                status,
	output logic [63:0]               host_address,
	output logic                      evicted_valid,
	output logic [63:0]               evicted_base,
	output logic [pmc_pkg::CNT_W-1:0] released_count
);

	localparam int AW = pmc_pkg::ADDR_W;
	localparam int PAGE_SHIFT_W = pmc_pkg::PAGE_SHIFT;

	// captured request
	pmc_pkg::op_t              op_q;
	logic [1:0]                img_q;
	logic [pmc_pkg::TAG_W-1:0] page_q;
	logic [PAGE_SHIFT_W-1:0]   off_q;
	logic [63:0]               mbase_q;
	logic                      ok_q;

	// per image state
	logic [63:0] use_ctr_q [pmc_pkg::NUM_IMAGES];
	logic        empty_q   [pmc_pkg::NUM_IMAGES];

	// scan state
	logic [AW-1:0]             idx_q;
	logic                      rd_vld_s1;
	logic [AW-1:0]             rd_addr_s1;
	logic                      found_q;
	logic [63:0]               min_q;
	logic [AW-1:0]             best_addr_q;
	pmc_pkg::entry_t           best_q;
	logic [pmc_pkg::CNT_W-1:0] cnt_q;

	// memory ports
	logic            we;
	logic [AW-1:0]   waddr;
	pmc_pkg::entry_t wdata;
	logic            re;
	logic [AW-1:0]   raddr;
	pmc_pkg::entry_t rdata;

	logic [AW-1:0] set_base;
	logic [AW-1:0] img_base;
	logic          img_oob;
	logic          take;

	// result helpers
	logic                      cnt_inc;
	logic [pmc_pkg::CNT_W-1:0] cnt_fin;
	logic                      hit_ok;
	logic                      ev_ok;

	pmc_ram #(
		.WIDTH ($bits(pmc_pkg::entry_t)),
		.DEPTH (pmc_pkg::TOTAL_N)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// address of the request's image and set
	assign img_base = AW'(img_q) * AW'(pmc_pkg::LOC_N);
	assign set_base = img_base
		+ AW'(page_q % pmc_pkg::TAG_W'(pmc_pkg::SETS)) * AW'(pmc_pkg::WAYS);
	assign img_oob  = ({30'd0, img_q} >= pmc_pkg::NUM_IMAGES);

	// read port
	assign re    = cmd.scan_rd | cmd.sweep_rd;
	assign raddr = cmd.sweep_rd ? img_base + AW'(idx_q[pmc_pkg::LOC_W-1:0])
		: set_base + AW'(idx_q[pmc_pkg::WAY_W-1:0]);

	// status to controller
	always_comb begin
		sts.quick = (op_q == pmc_pkg::OP_NONE) || img_oob
			|| ((op_q == pmc_pkg::OP_INVAL) && empty_q[img_q]);
		sts.inval = (op_q == pmc_pkg::OP_INVAL);
		sts.clear_last = (idx_q == AW'(pmc_pkg::TOTAL_N - 1));
		sts.scan_last = (idx_q[pmc_pkg::WAY_W-1:0] == pmc_pkg::WAY_W'(pmc_pkg::WAYS - 1));
		sts.sweep_last = (idx_q[pmc_pkg::LOC_W-1:0] == pmc_pkg::LOC_W'(pmc_pkg::LOC_N - 1));
	end

	// candidate selection for the returned way
	always_comb begin
		take = 1'b0;
		if (op_q == pmc_pkg::OP_LOOKUP) begin
			take = !found_q && (rdata.tag == page_q);
		end else if (op_q == pmc_pkg::OP_FILL) begin
			take = (rdata.stamp < min_q) || (!found_q && (rdata.stamp == min_q));
		end
	end

	// write port
	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = '0;
		if (cmd.clear_wr) begin
			we = 1'b1;
		end else if (rd_vld_s1 && (op_q == pmc_pkg::OP_INVAL)) begin
			we = rdata.valid;
			waddr = rd_addr_s1;
		end else if (cmd.finish && found_q) begin
			we = 1'b1;
			waddr = best_addr_q;
			wdata = best_q;
			if (op_q == pmc_pkg::OP_LOOKUP) begin
				wdata.stamp = use_ctr_q[img_q];
			end else if (ok_q) begin
				wdata.valid = 1'b1;
				wdata.tag = page_q;
				wdata.base = mbase_q;
			end else begin
				wdata.valid = 1'b0;
				if (best_q.valid) wdata.base = '0;
			end
		end
	end

	// released count including the way read in the last sweep cycle
	assign cnt_inc = rd_vld_s1 && (op_q == pmc_pkg::OP_INVAL) && rdata.valid
		&& (cnt_q != '1);
	assign cnt_fin = cnt_inc ? cnt_q + pmc_pkg::CNT_W'(1) : cnt_q;
	assign hit_ok  = found_q && best_q.valid;
	assign ev_ok   = found_q && best_q.valid;

	// request capture (payload)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			img_q   <= image;
			page_q  <= guest_address[63:pmc_pkg::PAGE_SHIFT];
			off_q   <= guest_address[pmc_pkg::PAGE_SHIFT-1:0];
			mbase_q <= mapped_base;
			ok_q    <= map_ok;
		end
		if (rd_vld_s1 && take) begin
			min_q       <= rdata.stamp;
			best_addr_q <= rd_addr_s1;
			best_q      <= rdata;
		end else if (cmd.dispatch) begin
			min_q <= use_ctr_q[img_q];
		end
		rd_addr_s1 <= raddr;
	end

	// control, counters and per image state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= pmc_pkg::OP_LOOKUP;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			cnt_q     <= '0;
			for (int i = 0; i < pmc_pkg::NUM_IMAGES; i++) begin
				use_ctr_q[i] <= '0;
				empty_q[i]   <= 1'b1;
			end
		end else begin
			rd_vld_s1 <= re;
			if (cmd.load) op_q <= pmc_pkg::op_t'(operation);
			if (cmd.dispatch) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				cnt_q   <= '0;
			end else if (cmd.clear_wr || re) begin
				idx_q <= idx_q + AW'(1);
			end
			if (rd_vld_s1 && take) found_q <= 1'b1;
			// count released mappings, saturating
			if (cnt_inc) begin
				cnt_q <= cnt_fin;
			end
			if (cmd.finish && found_q) begin
				if (op_q == pmc_pkg::OP_LOOKUP) begin
					use_ctr_q[img_q] <= use_ctr_q[img_q] + 64'd1;
				end else if (ok_q) begin
					empty_q[img_q] <= 1'b0;
				end
			end
			if (cmd.sweep_fin) begin
				use_ctr_q[img_q] <= '0;
				empty_q[img_q]   <= 1'b1;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.quick | cmd.finish | cmd.sweep_fin;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.quick) begin
			status <= (op_q == pmc_pkg::OP_LOOKUP) ? pmc_pkg::ST_MISS
				: (op_q == pmc_pkg::OP_INVAL) ? pmc_pkg::ST_INVAL : pmc_pkg::ST_NOWAY;
			host_address   <= '0;
			evicted_valid  <= 1'b0;
			evicted_base   <= '0;
			released_count <= '0;
		end else if (cmd.sweep_fin) begin
			status         <= pmc_pkg::ST_INVAL;
			host_address   <= '0;
			evicted_valid  <= 1'b0;
			evicted_base   <= '0;
			released_count <= cnt_fin;
		end else if (cmd.finish) begin
			released_count <= '0;
			if (op_q == pmc_pkg::OP_LOOKUP) begin
				status        <= hit_ok ? pmc_pkg::ST_HIT : pmc_pkg::ST_MISS;
				host_address  <= hit_ok
					? best_q.base + {{(64 - PAGE_SHIFT_W){1'b0}}, off_q} : '0;
				evicted_valid <= 1'b0;
				evicted_base  <= '0;
			end else begin
				status        <= !found_q ? pmc_pkg::ST_NOWAY
					: ok_q ? pmc_pkg::ST_FILLED : pmc_pkg::ST_FAILED;
				host_address  <= '0;
				evicted_valid <= ev_ok;
				evicted_base  <= ev_ok ? best_q.base : '0;
			end
		end
	end

endmodule

// ===== src/page_map_cache_lru_unit.sv =====
// Top level of the page map cache: controller plus datapath.
// Depends on pmc_pkg, pmc_ctrl, pmc_dp (and pmc_ram through pmc_dp).
// Lookup and fill read each way of the set once from the single way RAM.
// Invalidate sweeps every way of the image, one way per cycle; requests with nothing to do return without a scan.
// Result shows on done in the cycle busy drops; receiver cannot stall.
// After reset a clearing pass over all NUM_IMAGES*SETS*WAYS entries holds busy high.
module page_map_cache_lru_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [1:0]                image,
	input  logic [63:0]               guest_address,
	input  logic [63:0]               mapped_base,
	input  logic                      map_ok,
	output logic                      done,
	output logic [2:0]                status,
	output logic [63:0]               host_address,
	output logic                      evicted_valid,
	output logic [63:0]               evicted_base,
	output logic [pmc_pkg::CNT_W-1:0] released_count
);

	pmc_pkg::cmd_t cmd;
	pmc_pkg::sts_t sts;

	pmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	pmc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.operation      (operation),
		.image          (image),
		.guest_address  (guest_address),
		.mapped_base    (mapped_base),
		.map_ok         (map_ok),
		.done           (done),
		.status         (status),
		.host_address   (host_address),
		.evicted_valid  (evicted_valid),
		.evicted_base   (evicted_base),
		.released_count (released_count)
	);

	// a result appears only once the unit is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// an accepted transfer starts work
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transfer did not start");

	// only defined status codes
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= pmc_pkg::ST_INVAL)) else $error("bad status");

	// host address only on a hit
	a_host_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != pmc_pkg::ST_HIT) |-> host_address == '0)
		else $error("host address without hit");

	// released count only on invalidate
	a_cnt_inval: assert property (@(posedge clk) disable iff (!arst_n)
		(done && released_count != '0) |-> status == pmc_pkg::ST_INVAL)
		else $error("count without invalidate");

endmodule
